FILE: src/pfb_pkg.sv
// Shared types and constants for the page framebuffer rectangle fill block.
`timescale 1ns / 1ps

package pfb_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int PAGE_COUNT_DEF  = 8;
    localparam int ROWS_PER_PAGE   = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] WIDTH_RESET = 8'd128;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pos_x;
        logic [6:0] pos_y;
        logic [7:0] rect_width;
        logic [6:0] rect_height;
        logic       color;
    } pfb_in_t;

    typedef struct packed {
        logic pixel_value;
        logic in_range;
    } pfb_out_t;

    typedef enum logic [1:0] {
        OP_SKIP,
        OP_DRAW,
        OP_READ
    } pfb_op_t;

    typedef struct packed {
        pfb_op_t    op;
        logic       color;
        logic [8:0] width;
        logic [7:0] x_first;
        logic [7:0] x_last;
        logic [3:0] page_first;
        logic [3:0] page_last;
        logic [2:0] row_first;
        logic [2:0] row_last;
    } pfb_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_MODIFY,
        ST_DONE
    } pfb_state_t;

endpackage

FILE: src/pfb_front.sv
// Front end: width register, command acceptance, clipping and classification.
`timescale 1ns / 1ps

module pfb_front #(
    parameter int MAX_COLUMNS = pfb_pkg::MAX_COLUMNS_DEF,
    parameter int PAGE_COUNT  = pfb_pkg::PAGE_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_data,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  pfb_pkg::pfb_in_t cmd_word,
    input  logic             clear_busy,
    output logic             q_valid,
    input  logic             q_ready,
    output pfb_pkg::pfb_cmd_t q_cmd
);

    localparam logic [8:0] MAXC_V = 9'(MAX_COLUMNS);
    localparam logic [7:0] ROWS_V = 8'(PAGE_COUNT * pfb_pkg::ROWS_PER_PAGE);

    logic [7:0] width_reg;
    logic [7:0] width_next;
    logic [8:0] w_eff;
    logic [8:0] x_sum;
    logic [8:0] x_end;
    logic [8:0] x_last_full;
    logic [7:0] y_sum;
    logic [7:0] y_end;
    logic [7:0] y_last;
    logic       draw_ok;
    logic       read_ok;

    assign width_next = cfg_we ? cfg_data : width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= pfb_pkg::WIDTH_RESET;
        end
        else
        begin
            width_reg <= width_next;
        end
    end

    // Saturate the stride and clip the rectangle to the display.
    always_comb
    begin
        w_eff       = ({1'b0, width_reg} > MAXC_V) ? MAXC_V : {1'b0, width_reg};
        x_sum       = {1'b0, cmd_word.pos_x} + {1'b0, cmd_word.rect_width};
        x_end       = (x_sum < w_eff) ? x_sum : w_eff;
        x_last_full = x_end - 9'd1;
        y_sum       = {1'b0, cmd_word.pos_y} + {1'b0, cmd_word.rect_height};
        y_end       = (y_sum < ROWS_V) ? y_sum : ROWS_V;
        y_last      = y_end - 8'd1;
        draw_ok     = ({1'b0, cmd_word.pos_x} < x_end) && ({1'b0, cmd_word.pos_y} < y_end);
        read_ok     = ({1'b0, cmd_word.pos_x} < w_eff) && ({1'b0, cmd_word.pos_y} < ROWS_V);
    end

    always_comb
    begin
        q_cmd.color      = cmd_word.color;
        q_cmd.width      = w_eff;
        q_cmd.x_first    = cmd_word.pos_x;
        q_cmd.page_first = cmd_word.pos_y[6:3];
        q_cmd.row_first  = cmd_word.pos_y[2:0];
        if (cmd_word.cmd == pfb_pkg::CMD_READ)
        begin
            q_cmd.op        = read_ok ? pfb_pkg::OP_READ : pfb_pkg::OP_SKIP;
            q_cmd.x_last    = cmd_word.pos_x;
            q_cmd.page_last = cmd_word.pos_y[6:3];
            q_cmd.row_last  = cmd_word.pos_y[2:0];
        end
        else
        begin
            q_cmd.op        = draw_ok ? pfb_pkg::OP_DRAW : pfb_pkg::OP_SKIP;
            q_cmd.x_last    = x_last_full[7:0];
            q_cmd.page_last = y_last[6:3];
            q_cmd.row_last  = y_last[2:0];
        end
    end

    assign q_valid   = cmd_valid && !clear_busy;
    assign cmd_ready = q_ready && !clear_busy;

endmodule

FILE: src/pfb_queue.sv
// Short command queue between the front end and the pixel engine.
`timescale 1ns / 1ps

module pfb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  pfb_pkg::pfb_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pfb_pkg::pfb_cmd_t pop_cmd
);

    localparam int QAW = (pfb_pkg::QUEUE_DEPTH > 1) ? $clog2(pfb_pkg::QUEUE_DEPTH) : 1;
    localparam logic [QAW-1:0] LAST_PTR = QAW'(pfb_pkg::QUEUE_DEPTH - 1);
    localparam logic [QAW:0]   FULL_CNT = (QAW + 1)'(pfb_pkg::QUEUE_DEPTH);

    pfb_pkg::pfb_cmd_t entry_reg [pfb_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: src/pfb_back.sv
// Pixel engine: frame store, clearing pass, byte read-modify-write walker, result register.
`timescale 1ns / 1ps

module pfb_back #(
    parameter int MAX_COLUMNS = pfb_pkg::MAX_COLUMNS_DEF,
    parameter int PAGE_COUNT  = pfb_pkg::PAGE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  pfb_pkg::pfb_cmd_t q_cmd,
    output logic              clear_busy,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pfb_pkg::pfb_out_t rsp_word
);

    localparam int DEPTH = MAX_COLUMNS * PAGE_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [7:0] mem [DEPTH];

    pfb_pkg::pfb_state_t state_reg;
    pfb_pkg::pfb_state_t state_next;
    logic [AW-1:0]       clr_reg;
    logic [AW-1:0]       clr_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    pfb_pkg::pfb_cmd_t cur_reg;
    pfb_pkg::pfb_cmd_t cur_next;
    logic [7:0]        x_reg;
    logic [7:0]        x_next;
    logic [3:0]        page_reg;
    logic [3:0]        page_next;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     base_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    pfb_pkg::pfb_out_t res_reg;
    pfb_pkg::pfb_out_t res_next;
    pfb_pkg::pfb_out_t out_reg;
    pfb_pkg::pfb_out_t out_next;
    logic [7:0]        rd_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic [12:0]       base_prod;
    logic [2:0]        row_lo;
    logic [2:0]        row_hi;
    logic [7:0]        mask;
    logic              slot_free;

    assign base_prod = {4'b0, q_cmd.width} * {9'b0, q_cmd.page_first};
    assign row_lo    = (page_reg == cur_reg.page_first) ? cur_reg.row_first : 3'd0;
    assign row_hi    = (page_reg == cur_reg.page_last) ? cur_reg.row_last : 3'd7;
    assign mask      = (8'hFF << row_lo) & (8'hFF >> (3'd7 - row_hi));
    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cur_next       = cur_reg;
        x_next         = x_reg;
        page_next      = page_reg;
        base_next      = base_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = base_reg + AW'(x_reg);
        q_ready        = 1'b0;
        case (state_reg)
            pfb_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = pfb_pkg::ST_IDLE;
                end
            end
            pfb_pkg::ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cur_next  = q_cmd;
                    x_next    = q_cmd.x_first;
                    page_next = q_cmd.page_first;
                    base_next = base_prod[AW-1:0];
                    res_next  = '0;
                    if (q_cmd.op == pfb_pkg::OP_SKIP)
                    begin
                        state_next = pfb_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = pfb_pkg::ST_ISSUE;
                    end
                end
            end
            pfb_pkg::ST_ISSUE:
            begin
                mem_re     = 1'b1;
                addr_next  = mem_raddr;
                state_next = pfb_pkg::ST_MODIFY;
            end
            pfb_pkg::ST_MODIFY:
            begin
                if (cur_reg.op == pfb_pkg::OP_READ)
                begin
                    res_next.pixel_value = rd_reg[cur_reg.row_first];
                    res_next.in_range    = 1'b1;
                    state_next           = pfb_pkg::ST_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = cur_reg.color ? (rd_reg | mask) : (rd_reg & ~mask);
                    if (x_reg != cur_reg.x_last)
                    begin
                        x_next     = x_reg + 8'd1;
                        state_next = pfb_pkg::ST_ISSUE;
                    end
                    else if (page_reg != cur_reg.page_last)
                    begin
                        x_next     = cur_reg.x_first;
                        page_next  = page_reg + 4'd1;
                        base_next  = base_reg + AW'(cur_reg.width);
                        state_next = pfb_pkg::ST_ISSUE;
                    end
                    else
                    begin
                        state_next = pfb_pkg::ST_DONE;
                    end
                end
            end
            pfb_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = pfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfb_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        x_reg    <= x_next;
        page_reg <= page_next;
        base_reg <= base_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    assign clear_busy = (state_reg == pfb_pkg::ST_CLEAR);
    assign rsp_valid  = out_valid_reg;
    assign rsp_word   = out_reg;

endmodule

FILE: src/page_framebuffer_rect_fill.sv
// Top level of the page framebuffer with rectangle fill and pixel read.
`timescale 1ns / 1ps

//  channel   signals                              direction  transfers
//  cmd       cmd_valid / cmd_ready / cmd_word     in         one command word
//  rsp       rsp_valid / rsp_ready / rsp_word     out        one result word per command
//  cfg       cfg_we / cfg_data                    in         display width, no wait
//
//  A draw reads each covered store byte and then writes it back, one byte at a
//  time, before its result word; a read fetches a single byte, and a skipped
//  command goes straight to its result word. The engine takes no new command
//  until that result word has been moved into the output register.
//  After reset a clearing pass writes zero to all MAX_COLUMNS*PAGE_COUNT bytes
//  (1024 bytes by default) with cmd_ready low; cfg writes are taken as ever.
//  Commands queue up while the engine works or a result waits on rsp_ready.

module page_framebuffer_rect_fill #(
    parameter int MAX_COLUMNS = pfb_pkg::MAX_COLUMNS_DEF,
    parameter int PAGE_COUNT  = pfb_pkg::PAGE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  pfb_pkg::pfb_in_t  cmd_word,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output pfb_pkg::pfb_out_t rsp_word,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data
);

    // Front to queue.
    logic              fq_valid;
    logic              fq_ready;
    pfb_pkg::pfb_cmd_t fq_cmd;

    // Queue to engine.
    logic              qb_valid;
    logic              qb_ready;
    pfb_pkg::pfb_cmd_t qb_cmd;

    // High while the store is being wiped after reset.
    logic              clear_busy;

    // Clip the command against the current width and classify it.
    pfb_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .PAGE_COUNT  (PAGE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_word   (cmd_word),
        .clear_busy (clear_busy),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_cmd      (fq_cmd)
    );

    // Hold classified commands so the host is not stalled by a long fill.
    pfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // Walk the covered bytes page by page, column by column.
    pfb_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .PAGE_COUNT  (PAGE_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_cmd      (qb_cmd),
        .clear_busy (clear_busy),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_word   (rsp_word)
    );

    // No command enters while the store is being wiped.
    assert property (@(posedge clk) disable iff (!rst_n) clear_busy |-> !cmd_ready)
        else $error("command accepted during clearing pass");

    // A pixel can only read as set when the read was in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_word.in_range) |-> !rsp_word.pixel_value)
        else $error("pixel set on an out-of-range or draw result");

    // No result can exist before any command got through.
    assert property (@(posedge clk) disable iff (!rst_n) clear_busy |-> !rsp_valid)
        else $error("result presented during clearing pass");

endmodule
